// ===== rtl/srps_pkg.sv =====
// Package with the shared constants, codes and types of the pair stack.
`timescale 1ns / 1ps
package srps_pkg;

    localparam int DEPTH   = 16;
    localparam int DEPTH_W = $clog2(DEPTH);
    localparam int SDEP_W  = 5;
    localparam int CMP_W   = (DEPTH_W > SDEP_W) ? DEPTH_W : SDEP_W;
    localparam int NODE_W  = 32;
    localparam int COST_W  = 32;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_FILL   = 2'd2,
        OP_SEARCH = 2'd3
    } t_op;

    typedef struct packed {
        t_op                 operation;
        logic [NODE_W-1:0]   node_in;
        logic [COST_W-1:0]   cost_in;
        logic [SDEP_W-1:0]   search_depth;
    } t_item;

    typedef struct packed {
        logic [NODE_W-1:0] node_out;
        logic [COST_W-1:0] cost_out;
        logic              found;
    } t_result;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

// ===== rtl/srps_if.sv =====
// Handshake interfaces for the input and result channels of the pair stack.
`timescale 1ns / 1ps
interface srps_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   operation;
    logic [srps_pkg::NODE_W-1:0]  node_in;
    logic [srps_pkg::COST_W-1:0]  cost_in;
    logic [srps_pkg::SDEP_W-1:0]  search_depth;

    modport source (output valid, operation, node_in, cost_in, search_depth, input ready);
    modport sink   (input valid, operation, node_in, cost_in, search_depth, output ready);
endinterface

interface srps_out_if;
    logic                         valid;
    logic                         ready;
    logic [srps_pkg::NODE_W-1:0]  node_out;
    logic [srps_pkg::COST_W-1:0]  cost_out;
    logic                         found;

    modport source (output valid, node_out, cost_out, found, input ready);
    modport sink   (input valid, node_out, cost_out, found, output ready);
endinterface

// ===== rtl/shift_register_pair_stack.sv =====
// Top level of the pair stack: controller, datapath and channel wiring.
//
//   Channel  Direction  Fields
//   i_in     sink       operation, node_in, cost_in, search_depth
//   o_out    source     node_out, cost_out, found
//
// Each transaction is first captured in S_IDLE and then executed in S_EXEC,
// which updates the entries and loads the result register; a new transaction
// is taken only after the last one has executed. The result register lets
// the next transaction be captured while a result still waits; execution
// stalls only while that register is full and not being taken. Reset is
// synchronous and clears all entries to zero in the same cycle.
`timescale 1ns / 1ps
module shift_register_pair_stack (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srps_in_if.sink     i_in,
    srps_out_if.source  o_out
);
    import srps_pkg::*;

    t_cmd    cmd;
    t_item   item;
    t_result result;

    assign item.operation    = t_op'(i_in.operation);
    assign item.node_in      = i_in.node_in;
    assign item.cost_in      = i_in.cost_in;
    assign item.search_depth = i_in.search_depth;

    srps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    srps_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (item),
        .o_result (result)
    );

    assign o_out.node_out = result.node_out;
    assign o_out.cost_out = result.cost_out;
    assign o_out.found    = result.found;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |-> !(o_out.valid && !o_out.ready))
        else $error("Result register overwritten while its transaction waits.");

    a_load_exec_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.load && cmd.exec))
        else $error("Capture and execution in the same cycle.");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("Input taken again before the previous transaction executed.");

    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |=> o_out.valid)
        else $error("Executed transaction did not present a result.");
`endif

endmodule

// ===== rtl/srps_ctrl.sv =====
// Controller state machine that sequences capture, execution and result handoff.
`timescale 1ns / 1ps
module srps_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_ready,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output srps_pkg::t_cmd o_cmd
);
    import srps_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/srps_dp.sv =====
// Datapath with the shifting entry registers, the search compare and the result register.
`timescale 1ns / 1ps
module srps_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srps_pkg::t_cmd    i_cmd,
    input  srps_pkg::t_item   i_item,
    output srps_pkg::t_result o_result
);
    import srps_pkg::*;

    logic [NODE_W-1:0] r_nodes [DEPTH];
    logic [COST_W-1:0] r_costs [DEPTH];
    t_item             r_item;
    t_result           r_result;
    logic [DEPTH-1:0]  hit_vec;
    t_result           n_result;

    assign o_result = r_result;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            hit_vec[i] = (r_nodes[i] == r_item.node_in)
                      && (CMP_W'(r_item.search_depth) > CMP_W'(i));
        end
    end

    always_comb begin
        n_result = '0;
        case (r_item.operation)
            OP_POP: begin
                n_result.node_out = r_nodes[0];
                n_result.cost_out = r_costs[0];
            end
            OP_SEARCH: begin
                n_result.found = |hit_vec;
            end
            default: begin
                n_result = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.exec) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_nodes[i] <= '0;
                r_costs[i] <= '0;
            end
        end else if (i_cmd.exec) begin
            case (r_item.operation)
                OP_PUSH: begin
                    for (int i = 1; i < DEPTH; i++) begin
                        r_nodes[i] <= r_nodes[i-1];
                        r_costs[i] <= r_costs[i-1];
                    end
                    r_nodes[0] <= r_item.node_in;
                    r_costs[0] <= r_item.cost_in;
                end
                OP_POP: begin
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        r_nodes[i] <= r_nodes[i+1];
                        r_costs[i] <= r_costs[i+1];
                    end
                    r_nodes[DEPTH-1] <= '0;
                    r_costs[DEPTH-1] <= '0;
                end
                OP_FILL: begin
                    for (int i = 0; i < DEPTH; i++) begin
                        r_nodes[i] <= r_item.node_in;
                        r_costs[i] <= r_item.cost_in;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== bench/pair_stack_checker.sv =====
// Checker that mirrors the pair stack from accepted transactions and compares every result.
`timescale 1ns / 1ps
module pair_stack_checker
    import srps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    srps_in_if   i_in,
    srps_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_hits
);

    localparam int REPORT_LIMIT = 10;

    logic [NODE_W-1:0] mirror_nodes [DEPTH];
    logic [COST_W-1:0] mirror_costs [DEPTH];
    t_result           expected_results [$];
    int                fail_count;
    int                checked;
    int                hits;

    function automatic t_result apply_stack_op(input t_item item);
        t_result res;
        int      span;
        int      k;
        res = '0;
        case (item.operation)
            OP_PUSH: begin
                for (k = DEPTH - 1; k > 0; k--) begin
                    mirror_nodes[k] = mirror_nodes[k-1];
                    mirror_costs[k] = mirror_costs[k-1];
                end
                mirror_nodes[0] = item.node_in;
                mirror_costs[0] = item.cost_in;
            end
            OP_POP: begin
                res.node_out = mirror_nodes[0];
                res.cost_out = mirror_costs[0];
                for (k = 0; k < DEPTH - 1; k++) begin
                    mirror_nodes[k] = mirror_nodes[k+1];
                    mirror_costs[k] = mirror_costs[k+1];
                end
                mirror_nodes[DEPTH-1] = '0;
                mirror_costs[DEPTH-1] = '0;
            end
            OP_FILL: begin
                for (k = 0; k < DEPTH; k++) begin
                    mirror_nodes[k] = item.node_in;
                    mirror_costs[k] = item.cost_in;
                end
            end
            default: begin
                span = (int'(item.search_depth) > DEPTH) ? DEPTH : int'(item.search_depth);
                for (k = 0; k < span; k++) begin
                    if (mirror_nodes[k] == item.node_in) begin
                        res.found = 1'b1;
                    end
                end
            end
        endcase
        return res;
    endfunction

    task automatic note_failure(input string msg);
        if (fail_count < REPORT_LIMIT) begin
            $display("%0t: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_item   item;
        t_result got;
        t_result want;
        int      k;
        if (!i_rst_n) begin
            for (k = 0; k < DEPTH; k++) begin
                mirror_nodes[k] = '0;
                mirror_costs[k] = '0;
            end
            expected_results.delete();
            fail_count = 0;
            checked    = 0;
            hits       = 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.node_out = i_res.node_out;
                got.cost_out = i_res.cost_out;
                got.found    = i_res.found;
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("Unexpected result: node %h cost %h found %b",
                                           got.node_out, got.cost_out, got.found));
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    if (got.found) begin
                        hits++;
                    end
                    if (got.node_out !== want.node_out || got.cost_out !== want.cost_out ||
                        got.found !== want.found) begin
                        note_failure($sformatf(
                            "Mismatch: expected node %h cost %h found %b; got %h %h %b",
                            want.node_out, want.cost_out, want.found,
                            got.node_out, got.cost_out, got.found));
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                item.operation    = t_op'(i_in.operation);
                item.node_in      = i_in.node_in;
                item.cost_in      = i_in.cost_in;
                item.search_depth = i_in.search_depth;
                expected_results.push_back(apply_stack_op(item));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_results.size();
        o_checked    <= checked;
        o_hits       <= hits;
    end

endmodule

// ===== bench/shift_register_pair_stack_tb.sv =====
// Top of the pair stack testbench: clock, reset, stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps
module shift_register_pair_stack_tb;
    import srps_pkg::*;

    localparam int RANDOM_COUNT = 1650;
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;

    logic i_clk = 1'b0;
    logic i_rst_n;

    srps_in_if  in_ch ();
    srps_out_if out_ch ();

    int fail_count;
    int pending;
    int checked;
    int hits;
    int op_counts [4];
    int idle_cycles;
    bit calm_phase;
    bit hold_request;

    shift_register_pair_stack dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    pair_stack_checker stack_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_res        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_hits       (hits)
    );

    always #1 i_clk = ~i_clk;

    task automatic send_item(input t_op op, input logic [NODE_W-1:0] node,
                             input logic [COST_W-1:0] cost, input logic [SDEP_W-1:0] sdep,
                             input bit allow_gap);
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= op;
        in_ch.node_in      <= node;
        in_ch.cost_in      <= cost;
        in_ch.search_depth <= sdep;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        op_counts[int'(op)]++;
        if (allow_gap && $urandom_range(0, 99) < 24) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
    endtask

    initial begin : result_sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (calm_phase) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= 24);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int                n;
        int                pick;
        t_op               op;
        logic [NODE_W-1:0] node;
        logic [COST_W-1:0] cost;
        logic [SDEP_W-1:0] sdep;
        calm_phase   = 1'b0;
        hold_request = 1'b0;
        for (n = 0; n < 4; n++) begin
            op_counts[n] = 0;
        end
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.operation    <= OP_PUSH;
        in_ch.node_in      <= '0;
        in_ch.cost_in      <= '0;
        in_ch.search_depth <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty stack, depth limits, pushes onto a full stack and fills.
        send_item(OP_POP,    32'h0,        32'h0,        5'd0,  1'b1);
        send_item(OP_SEARCH, 32'h0,        32'h0,        5'd0,  1'b1);
        send_item(OP_SEARCH, 32'h0,        32'h0,        5'd1,  1'b1);
        send_item(OP_PUSH,   32'hFFFFFFFF, 32'hFFFFFFFF, 5'd31, 1'b1);
        send_item(OP_PUSH,   32'h0,        32'h0,        5'd0,  1'b1);
        send_item(OP_SEARCH, 32'hFFFFFFFF, 32'h0,        5'd1,  1'b1);
        send_item(OP_SEARCH, 32'hFFFFFFFF, 32'h0,        5'd2,  1'b1);
        send_item(OP_POP,    32'h0,        32'h0,        5'd0,  1'b1);
        send_item(OP_POP,    32'h0,        32'h0,        5'd0,  1'b1);
        send_item(OP_FILL,   32'hA5A5A5A5, 32'h5A5A5A5A, 5'd0,  1'b1);
        send_item(OP_PUSH,   32'h1,        32'h2,        5'd0,  1'b1);
        send_item(OP_SEARCH, 32'hA5A5A5A5, 32'h0,        5'd16, 1'b1);
        send_item(OP_SEARCH, 32'h1,        32'hFFFFFFFF, 5'd17, 1'b1);
        send_item(OP_SEARCH, 32'h3,        32'h0,        5'd31, 1'b1);
        send_item(OP_POP,    32'h0,        32'h0,        5'd0,  1'b1);
        send_item(OP_FILL,   32'hFFFFFFFF, 32'h0,        5'd0,  1'b1);
        send_item(OP_SEARCH, 32'hFFFFFFFF, 32'h0,        5'd16, 1'b1);
        send_item(OP_FILL,   32'h0,        32'hFFFFFFFF, 5'd0,  1'b1);
        send_item(OP_POP,    32'h0,        32'h0,        5'd0,  1'b1);
        send_item(OP_SEARCH, 32'h0,        32'h0,        5'd31, 1'b1);

        for (n = 0; n < RANDOM_COUNT; n++) begin
            calm_phase = (n >= 700 && n < 1000);
            if (n == 1300) begin
                hold_request = 1'b1;
            end
            pick = $urandom_range(0, 99);
            case ((n / 100) % 3)
                0: op = (pick < 45) ? OP_PUSH : (pick < 65) ? OP_POP :
                        (pick < 95) ? OP_SEARCH : OP_FILL;
                1: op = (pick < 20) ? OP_PUSH : (pick < 65) ? OP_POP :
                        (pick < 95) ? OP_SEARCH : OP_FILL;
                default: op = (pick < 30) ? OP_PUSH : (pick < 60) ? OP_POP :
                              (pick < 95) ? OP_SEARCH : OP_FILL;
            endcase
            case ($urandom_range(0, 3))
                0, 1: node = $urandom_range(0, 7);
                2: node = $urandom;
                default: node = $urandom_range(0, 1) ? '1 : '0;
            endcase
            cost = $urandom;
            sdep = ($urandom_range(0, 99) < 80) ? SDEP_W'($urandom_range(0, 16)) :
                                                  SDEP_W'($urandom_range(17, 31));
            send_item(op, node, cost, sdep, !calm_phase);
        end
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d push, %0d pop, %0d fill and %0d search transactions.",
                 op_counts[int'(OP_PUSH)], op_counts[int'(OP_POP)],
                 op_counts[int'(OP_FILL)], op_counts[int'(OP_SEARCH)]);
        $display("Checked %0d results, %0d searches hit, %0d failures.",
                 checked, hits, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
